>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the mouse packet tracker.
// Needs nothing else; take in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true implies consequent true at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");

// Antecedent true implies consequent true at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");

// Expression must never hold.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: never expr");

`endif

>>> hw/rtl/ps2mt_pkg.sv
// Package for the PS/2 mouse packet tracker: constants, types, clamp helpers.
// No dependencies; used by ps2mt_pointer_step and ps2_mouse_packet_tracker.
`default_nettype none

package ps2mt_pkg;

    // Pointer position after reset
    localparam logic [9:0] START_COL = 10'd40;
    localparam logic [9:0] START_ROW = 10'd12;

    // Register reset values
    localparam logic [10:0] WIDTH_RST  = 11'd80;
    localparam logic [10:0] HEIGHT_RST = 11'd25;
    localparam logic [7:0]  PERIOD_RST = 8'd0;
    localparam logic [10:0] SIZE_MAX   = 11'd1024;

    // Register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    // Byte position within a packet
    localparam logic [1:0] IDX_HEADER = 2'd0;
    localparam logic [1:0] IDX_XDELTA = 2'd1;
    localparam logic [1:0] IDX_YDELTA = 2'd2;

    // Header bit positions
    localparam int HB_LEFT   = 0;
    localparam int HB_RIGHT  = 1;
    localparam int HB_MIDDLE = 2;
    localparam int HB_XSIGN  = 4;
    localparam int HB_YSIGN  = 5;
    localparam int HB_XOVF   = 6;
    localparam int HB_YOVF   = 7;

    // Gathered packet handed to the pointer step
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } t_packet;

    // Current tracker state seen by the pointer step
    typedef struct packed {
        logic [1:0] prev_count;
        logic [9:0] column;
        logic [9:0] row;
    } t_track;

    // Outcome of one complete packet
    typedef struct packed {
        logic       overflow;
        logic       left;
        logic       right;
        logic [1:0] count;
        logic       moved;
        logic [9:0] column;
        logic [9:0] row;
    } t_step_res;

    // Screen size as used by the clamp: 0 reads as 1, above 1024 as 1024
    function automatic logic [10:0] eff_size(input logic [10:0] v);
        logic [10:0] s;
        if (v == 11'd0) begin
            s = 11'd1;
        end else if (v > SIZE_MAX) begin
            s = SIZE_MAX;
        end else begin
            s = v;
        end
        return s;
    endfunction

    // Clamp a signed position into 0 .. size-1
    function automatic logic [9:0] clamp_pos(input logic signed [11:0] p,
                                             input logic [10:0] size);
        logic [10:0] lim;
        logic [9:0]  q;
        lim = size - 11'd1;
        if (p >= $signed({1'b0, size})) begin
            q = lim[9:0];
        end else if (p < 12'sd0) begin
            q = 10'd0;
        end else begin
            q = p[9:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ps2mt_pointer_step.sv
// Decodes one complete three-byte packet: overflow check, buttons, move and clamp.
// Depends on ps2mt_pkg.
`default_nettype none

module ps2mt_pointer_step (
    input  wire ps2mt_pkg::t_packet   i_pkt,
    input  wire ps2mt_pkg::t_track    i_track,
    input  wire logic [10:0]          i_width,
    input  wire logic [10:0]          i_height,
    output ps2mt_pkg::t_step_res      o_res
);

    logic [1:0]         w_count;
    logic signed [11:0] w_dx;
    logic signed [11:0] w_dy;
    logic signed [11:0] w_col;
    logic signed [11:0] w_row;

    // Button count and 9-bit signed deltas widened to 12 bits
    assign w_count = {1'b0, i_pkt.header[ps2mt_pkg::HB_LEFT]}
                   + {1'b0, i_pkt.header[ps2mt_pkg::HB_RIGHT]}
                   + {1'b0, i_pkt.header[ps2mt_pkg::HB_MIDDLE]};
    assign w_dx  = $signed({{4{i_pkt.header[ps2mt_pkg::HB_XSIGN]}}, i_pkt.x_byte});
    assign w_dy  = $signed({{4{i_pkt.header[ps2mt_pkg::HB_YSIGN]}}, i_pkt.y_byte});
    assign w_col = $signed({2'b00, i_track.column}) + w_dx;
    assign w_row = $signed({2'b00, i_track.row}) - w_dy;

    // Move only when the button count is unchanged, else record the new count
    always_comb begin
        o_res.overflow = i_pkt.header[ps2mt_pkg::HB_XOVF] | i_pkt.header[ps2mt_pkg::HB_YOVF];
        o_res.left     = i_pkt.header[ps2mt_pkg::HB_LEFT];
        o_res.right    = i_pkt.header[ps2mt_pkg::HB_RIGHT];
        o_res.count    = w_count;
        o_res.moved    = (w_count == i_track.prev_count);
        if (o_res.moved) begin
            o_res.column = ps2mt_pkg::clamp_pos(w_col, ps2mt_pkg::eff_size(i_width));
            o_res.row    = ps2mt_pkg::clamp_pos(w_row, ps2mt_pkg::eff_size(i_height));
        end else begin
            o_res.column = i_track.column;
            o_res.row    = i_track.row;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ps2_mouse_packet_tracker.sv
// PS/2 mouse packet tracker top level: byte gathering, state, tick counter, output word.
// Depends on ps2mt_pkg, ps2mt_pointer_step and assert_macros.svh.
//
//  channel   dir  handshake                     word
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  8-bit mouse byte
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  32-bit pointer status
//  cfg       in   i_cfg_we (index, data)          screen size, refresh period
//
// The decode of a byte runs combinationally from the input word through the pointer
// step into the state and the output register, which load together on acceptance.
// Synchronous active-low reset clears the packet state, puts the pointer at its
// start position and loads the register defaults. A stall on m_axis holds the
// output word; a new byte is still taken in the cycle the held word is taken.
`default_nettype none

module ps2_mouse_packet_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    // master side
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [9:0] column, [19:10] row,
                                               // [20] left_button, [21] right_button,
                                               // [23:22] buttons_pressed,
                                               // [24] packet_done, [25] packet_dropped,
                                               // [26] refresh_due, [31:27] zero
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [10:0] i_cfg_wdata
);

    `include "assert_macros.svh"

    // configuration registers
    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [7:0]  r_period;

    // packet state
    logic [1:0]  r_byte_index, n_byte_index;
    logic [7:0]  r_header,     n_header;
    logic [7:0]  r_x_byte,     n_x_byte;
    logic        r_left,       n_left;
    logic        r_right,      n_right;
    logic [1:0]  r_prev_count, n_prev_count;
    logic [9:0]  r_column,     n_column;
    logic [9:0]  r_row,        n_row;
    logic [7:0]  r_tick,       n_tick;

    // output register
    logic        r_out_valid;
    logic [26:0] r_out_word;
    logic [26:0] n_out_word;

    logic        w_in_acc;
    logic        w_done;
    logic        w_dropped;
    logic        w_refresh;
    logic        w_hdr_acc;
    logic        w_pkt_end;

    ps2mt_pkg::t_packet   w_pkt;
    ps2mt_pkg::t_track    w_track;
    ps2mt_pkg::t_step_res w_res;

    // input taken whenever the output register is free or being emptied
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_pkt   = '{header: r_header, x_byte: r_x_byte, y_byte: i_s_axis_tdata};
    assign w_track = '{prev_count: r_prev_count, column: r_column, row: r_row};

    ps2mt_pointer_step u_step (
        .i_pkt    (w_pkt),
        .i_track  (w_track),
        .i_width  (r_width),
        .i_height (r_height),
        .o_res    (w_res)
    );

    // next state for one byte
    always_comb begin
        n_byte_index = r_byte_index;
        n_header     = r_header;
        n_x_byte     = r_x_byte;
        n_left       = r_left;
        n_right      = r_right;
        n_prev_count = r_prev_count;
        n_column     = r_column;
        n_row        = r_row;
        n_tick       = r_tick;
        w_done       = 1'b0;
        w_dropped    = 1'b0;
        w_refresh    = 1'b0;

        unique case (r_byte_index)
            ps2mt_pkg::IDX_HEADER: begin
                n_header     = i_s_axis_tdata;
                n_byte_index = ps2mt_pkg::IDX_XDELTA;
            end
            ps2mt_pkg::IDX_XDELTA: begin
                n_x_byte     = i_s_axis_tdata;
                n_byte_index = ps2mt_pkg::IDX_YDELTA;
            end
            default: begin
                n_byte_index = ps2mt_pkg::IDX_HEADER;
                if (w_res.overflow) begin
                    w_dropped = 1'b1;
                end else begin
                    w_done   = 1'b1;
                    n_left   = w_res.left;
                    n_right  = w_res.right;
                    n_column = w_res.column;
                    n_row    = w_res.row;
                    if (!w_res.moved) begin
                        n_prev_count = w_res.count;
                    end
                end
            end
        endcase

        // refresh tick, skipped on a dropped packet
        if (!w_dropped) begin
            if (r_tick == r_period) begin
                w_refresh = 1'b1;
                n_tick    = 8'd0;
            end else begin
                n_tick = r_tick + 8'd1;
            end
        end

        n_out_word = {w_refresh, w_dropped, w_done, n_prev_count,
                      n_right, n_left, n_row, n_column};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ps2mt_pkg::WIDTH_RST;
            r_height <= ps2mt_pkg::HEIGHT_RST;
            r_period <= ps2mt_pkg::PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ps2mt_pkg::REG_WIDTH:  r_width  <= i_cfg_wdata;
                ps2mt_pkg::REG_HEIGHT: r_height <= i_cfg_wdata;
                ps2mt_pkg::REG_PERIOD: r_period <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= ps2mt_pkg::IDX_HEADER;
            r_header     <= 8'd0;
            r_x_byte     <= 8'd0;
            r_left       <= 1'b0;
            r_right      <= 1'b0;
            r_prev_count <= 2'd0;
            r_column     <= ps2mt_pkg::START_COL;
            r_row        <= ps2mt_pkg::START_ROW;
            r_tick       <= 8'd0;
        end else if (w_in_acc) begin
            r_byte_index <= n_byte_index;
            r_header     <= n_header;
            r_x_byte     <= n_x_byte;
            r_left       <= n_left;
            r_right      <= n_right;
            r_prev_count <= n_prev_count;
            r_column     <= n_column;
            r_row        <= n_row;
            r_tick       <= n_tick;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_word};

    // checks
    assign w_hdr_acc = w_in_acc && (r_byte_index == ps2mt_pkg::IDX_HEADER);
    assign w_pkt_end = w_in_acc && (w_done || w_dropped);

    `ASSERT_NEVER(a_index_range, i_clk, i_rst_n, r_byte_index > ps2mt_pkg::IDX_YDELTA)
    `ASSERT_NEVER(a_done_xor_drop, i_clk, i_rst_n, r_out_valid && r_out_word[24] && r_out_word[25])
    `ASSERT_NEXT(a_header_advance, i_clk, i_rst_n, w_hdr_acc, r_byte_index == ps2mt_pkg::IDX_XDELTA)
    `ASSERT_IMPLIES(a_packet_end, i_clk, i_rst_n, w_pkt_end, r_byte_index == ps2mt_pkg::IDX_YDELTA)

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for ps2_mouse_packet_tracker: byte stream in, pointer status out.
// Holds its own pointer/packet predictor; needs only ps2mt_pkg and the RTL.
// Directed table first, then packet-shaped random traffic across several register settings.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         SETTLE_WAIT  = 4;
    localparam int         PHASE_BYTES  = 305;
    localparam int         NUM_PHASES   = 6;
    localparam int         NUM_DIR_ROWS = 27;
    localparam logic [1:0] REG_SPARE    = 2'd3;   // unmapped index, must be ignored

    // Status word, lowest field in the lowest bits
    typedef struct packed {
        logic       refresh;
        logic       dropped;
        logic       done;
        logic [1:0] count;
        logic       right;
        logic       left;
        logic [9:0] row;
        logic [9:0] col;
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        logic       fixed;    // 1: use the typed status, else the predicted one
        t_status    want;
    } t_dir_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata  = 8'd0;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_addr      = 2'd0;
    logic [10:0] i_cfg_wdata     = 11'd0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;

    // Predictor state and register copies
    logic [1:0]  pkt_pos;
    logic [7:0]  hdr_held;
    logic [7:0]  xbyte_held;
    logic        left_held;
    logic        right_held;
    logic [1:0]  count_held;
    logic [9:0]  ptr_col;
    logic [9:0]  ptr_row;
    logic [7:0]  tick_cnt;
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    logic [7:0]  cfg_period;

    t_status     pending_status[$];
    t_dir_row    dir_rows[NUM_DIR_ROWS];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [2:0]  last_buttons = 3'd0;

    // Receiver stall pattern state
    int          sink_span = 0;
    int          sink_mode = 0;
    logic [7:0]  sink_mask = 8'hFF;
    logic [2:0]  sink_phase = 3'd0;

    t_status     got_status;
    t_status     want_status;

    ps2_mouse_packet_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Screen size as the clamp sees it
    function automatic int screen_span(input logic [10:0] v);
        if (v == 11'd0) return 1;
        if (v > 11'd1024) return 1024;
        return int'(v);
    endfunction

    function automatic logic [9:0] fit_to(input int p, input int span);
        if (p >= span) p = span - 1;
        if (p < 0) p = 0;
        return 10'(p);
    endfunction

    function automatic t_status word_of(input int c, input int r, input bit l, input bit rb,
                                       input int n, input bit d, input bit dr, input bit rf);
        t_status s;
        s = '{refresh: rf, dropped: dr, done: d, count: 2'(n), right: rb, left: l,
              row: 10'(r), col: 10'(c)};
        return s;
    endfunction

    // Advance the packet tracker by one mouse byte, return the status it shows
    function automatic t_status track_byte(input logic [7:0] b);
        t_status    s;
        logic       ticks;
        logic [1:0] n;
        int         dx;
        int         dy;
        s     = '0;
        ticks = 1'b1;
        case (pkt_pos)
            ps2mt_pkg::IDX_HEADER: begin
                hdr_held = b;
                pkt_pos  = ps2mt_pkg::IDX_XDELTA;
            end
            ps2mt_pkg::IDX_XDELTA: begin
                xbyte_held = b;
                pkt_pos    = ps2mt_pkg::IDX_YDELTA;
            end
            default: begin
                pkt_pos = ps2mt_pkg::IDX_HEADER;
                if (hdr_held[ps2mt_pkg::HB_XOVF] || hdr_held[ps2mt_pkg::HB_YOVF]) begin
                    s.dropped = 1'b1;
                    ticks     = 1'b0;
                end else begin
                    s.done     = 1'b1;
                    left_held  = hdr_held[ps2mt_pkg::HB_LEFT];
                    right_held = hdr_held[ps2mt_pkg::HB_RIGHT];
                    n = 2'(left_held) + 2'(right_held) + 2'(hdr_held[ps2mt_pkg::HB_MIDDLE]);
                    if (n == count_held) begin
                        // 9-bit deltas; Y grows upwards so it is subtracted from the row
                        dx = int'(xbyte_held) - (hdr_held[ps2mt_pkg::HB_XSIGN] ? 256 : 0);
                        dy = int'(b) - (hdr_held[ps2mt_pkg::HB_YSIGN] ? 256 : 0);
                        ptr_col = fit_to(int'(ptr_col) + dx, screen_span(cfg_width));
                        ptr_row = fit_to(int'(ptr_row) - dy, screen_span(cfg_height));
                    end else begin
                        count_held = n;
                    end
                end
            end
        endcase
        // dropped packets do not advance the refresh tick
        if (ticks) begin
            if (tick_cnt == cfg_period) begin
                s.refresh = 1'b1;
                tick_cnt  = 8'd0;
            end else begin
                tick_cnt = tick_cnt + 8'd1;
            end
        end
        s.col   = ptr_col;
        s.row   = ptr_row;
        s.left  = left_held;
        s.right = right_held;
        s.count = count_held;
        return s;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Send one byte; sender runs in bursts with random gaps between them
    task automatic push_byte(input logic [7:0] b, input logic fixed, input t_status want);
        int      gap;
        t_status predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predicted = track_byte(b);
        pending_status.push_back(fixed ? want : predicted);
    endtask

    // Stop sending and wait until every status word has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Back-to-back register writes, spare index first; block must be idle
    task automatic set_regs(input logic [10:0] w, input logic [10:0] h, input logic [10:0] p);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_SPARE;
        i_cfg_wdata <= 11'($urandom_range(0, 2047));
        @(posedge i_clk);
        i_cfg_addr  <= ps2mt_pkg::REG_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_addr  <= ps2mt_pkg::REG_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_addr  <= ps2mt_pkg::REG_PERIOD;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
        cfg_period = p[7:0];
        @(posedge i_clk);
    endtask

    // Delta byte: half small moves, a quarter anything, a quarter the far end
    function automatic logic [7:0] pick_delta(input logic neg);
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            3: return neg ? 8'h00 : 8'hFF;
            default: return neg ? 8'(256 - $urandom_range(1, 24)) : 8'($urandom_range(0, 24));
        endcase
    endfunction

    // Mostly whole packets with random content, some stray bytes and cut packets
    task automatic random_traffic(input int n_bytes);
        int         sent;
        int         pick;
        logic [7:0] hdr;
        logic [1:0] ovf;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 11);
            if (pick == 0) begin
                push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                sent++;
            end else begin
                if ($urandom_range(0, 3) == 0) last_buttons = 3'($urandom_range(0, 7));
                ovf = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : 2'd0;
                hdr = {ovf, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), last_buttons};
                push_byte(hdr, 1'b0, '0);
                push_byte(pick_delta(hdr[ps2mt_pkg::HB_XSIGN]), 1'b0, '0);
                sent += 2;
                // a cut packet leaves the next one out of step
                if (pick != 1) begin
                    push_byte(pick_delta(hdr[ps2mt_pkg::HB_YSIGN]), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: stall mode and mask are drawn anew whenever the current random span runs out
    always @(posedge i_clk) begin
        if (sink_span == 0) begin
            sink_span = $urandom_range(50, 400);
            sink_mode = $urandom_range(0, 3);
            sink_mask = 8'($urandom_range(1, 255));
        end
        sink_span--;
        sink_phase = sink_phase + 3'd1;
        case (sink_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_axis_tready <= sink_mask[sink_phase];
        endcase
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_status.size() == 0) begin
                $error("status word with none expected: %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want_status = pending_status.pop_front();
                got_status  = t_status'(o_m_axis_tdata[26:0]);
                check_field("column", want_status.col, got_status.col);
                check_field("row", want_status.row, got_status.row);
                check_field("left_button", want_status.left, got_status.left);
                check_field("right_button", want_status.right, got_status.right);
                check_field("buttons_pressed", want_status.count, got_status.count);
                check_field("packet_done", want_status.done, got_status.done);
                check_field("packet_dropped", want_status.dropped, got_status.dropped);
                check_field("refresh_due", want_status.refresh, got_status.refresh);
                check_field("pad", 0, o_m_axis_tdata[31:27]);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int          ph;
        logic [10:0] w;
        logic [10:0] h;
        logic [10:0] p;

        pkt_pos    = ps2mt_pkg::IDX_HEADER;
        hdr_held   = 8'd0;
        xbyte_held = 8'd0;
        left_held  = 1'b0;
        right_held = 1'b0;
        count_held = 2'd0;
        ptr_col    = ps2mt_pkg::START_COL;
        ptr_row    = ps2mt_pkg::START_ROW;
        tick_cnt   = 8'd0;
        cfg_width  = ps2mt_pkg::WIDTH_RST;
        cfg_height = ps2mt_pkg::HEIGHT_RST;
        cfg_period = ps2mt_pkg::PERIOD_RST;

        // Directed rows; screen 20x8 so the start position lies off screen
        dir_rows[0]  = {8'h00, 1'b1, word_of(40, 12, 0, 0, 0, 0, 0, 1)};
        dir_rows[1]  = {8'h00, 1'b1, word_of(40, 12, 0, 0, 0, 0, 0, 1)};
        dir_rows[2]  = {8'h00, 1'b1, word_of(19, 7, 0, 0, 0, 1, 0, 1)};   // first move clamps
        dir_rows[3]  = {8'hC0, 1'b1, word_of(19, 7, 0, 0, 0, 0, 0, 1)};   // both overflows
        dir_rows[4]  = {8'hFF, 1'b1, word_of(19, 7, 0, 0, 0, 0, 0, 1)};
        dir_rows[5]  = {8'hFF, 1'b1, word_of(19, 7, 0, 0, 0, 0, 1, 0)};   // dropped, no tick
        dir_rows[6]  = {8'h80, 1'b0, t_status'(0)};                       // Y overflow only
        dir_rows[7]  = {8'h12, 1'b0, t_status'(0)};
        dir_rows[8]  = {8'h34, 1'b0, t_status'(0)};
        dir_rows[9]  = {8'h40, 1'b0, t_status'(0)};                       // X overflow only
        dir_rows[10] = {8'h00, 1'b0, t_status'(0)};
        dir_rows[11] = {8'h00, 1'b0, t_status'(0)};
        dir_rows[12] = {8'h07, 1'b0, t_status'(0)};                       // count changes
        dir_rows[13] = {8'h7F, 1'b0, t_status'(0)};
        dir_rows[14] = {8'h80, 1'b1, word_of(19, 7, 1, 1, 3, 1, 0, 1)};   // count only
        dir_rows[15] = {8'h0F, 1'b0, t_status'(0)};
        dir_rows[16] = {8'h7F, 1'b0, t_status'(0)};
        dir_rows[17] = {8'h80, 1'b1, word_of(19, 0, 1, 1, 3, 1, 0, 1)};   // max +X, +Y 128
        dir_rows[18] = {8'h37, 1'b0, t_status'(0)};                       // both signs
        dir_rows[19] = {8'h00, 1'b0, t_status'(0)};
        dir_rows[20] = {8'h00, 1'b0, t_status'(0)};                       // -256 on both
        dir_rows[21] = {8'h04, 1'b0, t_status'(0)};                       // middle only
        dir_rows[22] = {8'hFF, 1'b0, t_status'(0)};
        dir_rows[23] = {8'hFF, 1'b0, t_status'(0)};
        dir_rows[24] = {8'h02, 1'b0, t_status'(0)};                       // right only
        dir_rows[25] = {8'h05, 1'b0, t_status'(0)};
        dir_rows[26] = {8'hFB, 1'b0, t_status'(0)};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_regs(11'd20, 11'd8, 11'd0);
        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            push_byte(dir_rows[i].data, dir_rows[i].fixed, dir_rows[i].want);
        end

        // Random phases; period drops from 255 to 3 to force the tick wrap
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin w = 11'd1024; h = 11'd1024; p = 11'd255;  end
                1: begin w = 11'd1;    h = 11'd1;    p = 11'd3;    end
                2: begin w = 11'd0;    h = 11'd0;    p = 11'h700;  end
                3: begin w = 11'd2047; h = 11'd2047; p = 11'd1;    end
                4: begin w = 11'd640;  h = 11'd480;  p = 11'd7;    end
                default: begin
                    w = 11'($urandom_range(1, 1100));
                    h = 11'($urandom_range(1, 1100));
                    p = 11'($urandom_range(0, 2047));
                end
            endcase
            set_regs(w, h, p);
            random_traffic(PHASE_BYTES);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
